>>> hdl/ist_pkg.sv
// Shared types, constants and helpers for the slot table with timeout.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ist_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_SLOTS);

    // Field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 16;
    localparam int IDX_W  = 4;
    localparam int AGE_W  = 17;
    localparam int LIM_W  = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TIMEOUT_LIMIT = 1'b0;   // word index paddr[2]
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(5);

    // Opcodes
    typedef logic [OP_W-1:0] t_opcode;
    localparam t_opcode OP_JOIN   = 3'd0;
    localparam t_opcode OP_INSERT = 3'd1;
    localparam t_opcode OP_TICK   = 3'd2;
    localparam t_opcode OP_HEARD  = 3'd3;
    localparam t_opcode OP_READ   = 3'd4;

    // Request from the sequencer to the slot store
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              id_we;
        logic [SLOT_W-1:0] id_addr;
        logic [ID_W-1:0]   id_wdata;
        logic              age_we;
        logic [SLOT_W-1:0] age_addr;
        logic [AGE_W-1:0]  age_wdata;
    } t_store_req;

    // Registered read data from the slot store
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_store_rd;

    // Low bits of a slot number as carried in result_index
    function automatic logic [IDX_W-1:0] res_idx(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, slot};
        return wide[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/ist_in_if.sv
// Request channel of the slot table: valid/ready plus one request word.
// Depends on ist_pkg for field widths.
`default_nettype none

interface ist_in_if import ist_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   member_id;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output opcode, output member_id, output slot_index,
                    input ready);
    modport sink   (input valid, input opcode, input member_id, input slot_index,
                    output ready);

endinterface

`default_nettype wire

>>> hdl/ist_out_if.sv
// Response channel of the slot table: valid/ready plus one result word.
// Depends on ist_pkg for field widths.
`default_nettype none

interface ist_out_if import ist_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  result_index;
    logic [ID_W-1:0]   slot_id;
    logic              timed_out;
    logic [AGE_W-1:0]  slot_age;

    modport source (output valid, output found, output result_index, output slot_id,
                    output timed_out, output slot_age, input ready);
    modport sink   (input valid, input found, input result_index, input slot_id,
                    input timed_out, input slot_age, output ready);

endinterface

`default_nettype wire

>>> hdl/ist_cfg.sv
// APB-style register file holding the timeout limit.
// Depends on ist_pkg.
`default_nettype none

module ist_cfg import ist_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready,
    output      logic [LIM_W-1:0]   o_timeout_limit
);

    logic [LIM_W-1:0] r_limit;
    logic             wr_limit;

    assign pready   = 1'b1;
    assign wr_limit = psel && penable && pwrite && pready
                      && (paddr[PADDR_W-1] == REG_TIMEOUT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (wr_limit) begin
            r_limit <= pwdata[LIM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_TIMEOUT_LIMIT) begin
            prdata = {{(PDATA_W-LIM_W){1'b0}}, r_limit};
        end
    end

    assign o_timeout_limit = r_limit;

endmodule

`default_nettype wire

>>> hdl/ist_store.sv
// Slot store: id memory and age memory, one read port with registered data.
// Per-slot valid bits make never-written slots read as id 0, age 0. Depends on ist_pkg.
`default_nettype none

module ist_store import ist_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_req i_req,
    output      t_store_rd  o_rd
);

    logic [ID_W-1:0]  id_mem  [TABLE_SLOTS];
    logic [AGE_W-1:0] age_mem [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] r_id_vld;
    logic [TABLE_SLOTS-1:0] r_age_vld;
    logic [ID_W-1:0]        r_rd_id;
    logic [AGE_W-1:0]       r_rd_age;
    logic                   r_rd_id_vld;
    logic                   r_rd_age_vld;

    // Memory arrays: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.id_we) begin
            id_mem[i_req.id_addr] <= i_req.id_wdata;
        end
        if (i_req.age_we) begin
            age_mem[i_req.age_addr] <= i_req.age_wdata;
        end
        if (i_req.rd_en) begin
            r_rd_id  <= id_mem[i_req.rd_addr];
            r_rd_age <= age_mem[i_req.rd_addr];
        end
    end

    // Valid bits: clear at reset, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_vld     <= '0;
            r_age_vld    <= '0;
            r_rd_id_vld  <= 1'b0;
            r_rd_age_vld <= 1'b0;
        end else begin
            if (i_req.id_we) begin
                r_id_vld[i_req.id_addr] <= 1'b1;
            end
            if (i_req.age_we) begin
                r_age_vld[i_req.age_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_id_vld  <= r_id_vld[i_req.rd_addr];
                r_rd_age_vld <= r_age_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd.id  = r_rd_id_vld  ? r_rd_id  : '0;
    assign o_rd.age = r_rd_age_vld ? r_rd_age : '0;

endmodule

`default_nettype wire

>>> hdl/ist_ctrl.sv
// Sequencer: scans the slot store, does read-modify-write of ages,
// resolves join/insert and holds the result word. Depends on ist_pkg and the channel interfaces.
`default_nettype none

module ist_ctrl import ist_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LIM_W-1:0] i_timeout_limit,
    ist_in_if.sink                i_req,
    ist_out_if.source             o_rsp,
    output      t_store_req       o_store_req,
    input  wire t_store_rd        i_store_rd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state;

    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pv;
    logic [SLOT_W-1:0] r_pa;

    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic [ID_W-1:0]   r_hit_id;
    logic [AGE_W-1:0]  r_hit_age;
    logic              r_free;
    logic [SLOT_W-1:0] r_free_idx;
    logic [AGE_W-1:0]  r_free_age;

    logic              r_ovld;
    logic              r_o_found;
    logic [IDX_W-1:0]  r_o_idx;
    logic [ID_W-1:0]   r_o_id;
    logic              r_o_tmo;
    logic [AGE_W-1:0]  r_o_age;

    logic                    acc;
    logic                    in_range;
    logic                    single;
    logic                    rd_en;
    logic                    out_load;
    logic [SLOT_W+IDX_W-1:0] idx_wide;
    logic [SLOT_W-1:0]       idx_addr;
    logic [AGE_W:0]          age_inc;
    logic [AGE_W-1:0]        age_cap;
    logic [AGE_W-1:0]        tick_age;
    logic                    res_found;
    logic [IDX_W-1:0]        res_i;
    logic [ID_W-1:0]         res_id;
    logic [AGE_W-1:0]        res_age;

    assign i_req.ready = (r_state == ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;

    assign in_range = {{CNT_W{1'b0}}, i_req.slot_index} < {{IDX_W{1'b0}}, N_CNT};
    assign single   = (r_op == OP_HEARD) || (r_op == OP_READ);
    assign idx_wide = {{SLOT_W{1'b0}}, r_idx};
    assign idx_addr = idx_wide[SLOT_W-1:0];

    assign rd_en    = (r_state == ST_SCAN) && (r_cnt < N_CNT);
    assign out_load = (r_state == ST_DONE) && (!r_ovld || o_rsp.ready);

    // Tick update: age+1, forced to limit+1 on free slots or past the limit
    assign age_inc  = {1'b0, i_store_rd.age} + {{AGE_W{1'b0}}, 1'b1};
    assign age_cap  = {1'b0, i_timeout_limit} + {{LIM_W{1'b0}}, 1'b1};
    assign tick_age = ((i_store_rd.id == '0) || (age_inc > {2'b00, i_timeout_limit}))
                      ? age_cap : age_inc[AGE_W-1:0];

    // Store requests
    always_comb begin
        o_store_req           = '0;
        o_store_req.rd_en     = rd_en;
        o_store_req.rd_addr   = single ? idx_addr : r_cnt[SLOT_W-1:0];
        o_store_req.age_addr  = r_pa;
        o_store_req.id_addr   = r_free_idx;
        o_store_req.id_wdata  = r_id;
        if (r_pv && (r_op == OP_TICK)) begin
            o_store_req.age_we    = 1'b1;
            o_store_req.age_wdata = tick_age;
        end
        if (r_pv && (r_op == OP_HEARD)) begin
            o_store_req.age_we    = 1'b1;
            o_store_req.age_wdata = '0;
        end
        // Join/insert without a match takes the first free slot
        if (out_load && !r_hit && r_free) begin
            o_store_req.id_we = 1'b1;
        end
    end

    // Result selection
    always_comb begin
        res_found = r_hit || r_free;
        res_i     = '0;
        res_id    = '0;
        res_age   = '0;
        if (r_hit) begin
            res_i   = res_idx(r_hit_idx);
            res_id  = r_hit_id;
            res_age = r_hit_age;
        end else if (r_free) begin
            res_i   = res_idx(r_free_idx);
            res_id  = r_id;
            res_age = r_free_age;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_pv <= rd_en;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_state <= ST_SCAN;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        case (i_req.opcode) inside
                            OP_JOIN, OP_INSERT, OP_TICK: r_cnt <= '0;
                            OP_HEARD, OP_READ:           r_cnt <= in_range ? '0 : N_CNT;
                            default:                     r_cnt <= N_CNT;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        r_cnt <= single ? N_CNT : r_cnt + {{SLOT_W{1'b0}}, 1'b1};
                    end
                    if (r_pv) begin
                        case (r_op) inside
                            OP_JOIN, OP_INSERT: begin
                                if (!r_free && (i_store_rd.id == '0)) begin
                                    r_free <= 1'b1;
                                end
                                if ((r_op == OP_JOIN) && !r_hit && (i_store_rd.id == r_id)) begin
                                    r_hit <= 1'b1;
                                end
                            end
                            OP_HEARD, OP_READ: r_hit <= 1'b1;
                            default: ;
                        endcase
                    end
                    if ((r_cnt == N_CNT) && !r_pv) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Item and scan payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_req.opcode;
            r_id  <= i_req.member_id;
            r_idx <= i_req.slot_index;
        end
        if (rd_en) begin
            r_pa <= o_store_req.rd_addr;
        end
        if (r_pv) begin
            if (((r_op == OP_JOIN) || (r_op == OP_INSERT)) && !r_free
                    && (i_store_rd.id == '0)) begin
                r_free_idx <= r_pa;
                r_free_age <= i_store_rd.age;
            end
            if (((r_op == OP_JOIN) && !r_hit && (i_store_rd.id == r_id)) || single) begin
                r_hit_idx <= r_pa;
                r_hit_id  <= i_store_rd.id;
                r_hit_age <= (r_op == OP_HEARD) ? '0 : i_store_rd.age;
            end
        end
    end

    // Output register: holds the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_load) begin
            r_ovld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_found <= res_found;
            r_o_idx   <= res_i;
            r_o_id    <= res_id;
            r_o_age   <= res_age;
            r_o_tmo   <= res_found && (res_age > {1'b0, i_timeout_limit});
        end
    end

    assign o_rsp.valid        = r_ovld;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.result_index = r_o_idx;
    assign o_rsp.slot_id      = r_o_id;
    assign o_rsp.timed_out    = r_o_tmo;
    assign o_rsp.slot_age     = r_o_age;

    // Age write-back never lands on the entry being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_store_req.age_we && o_store_req.rd_en) |-> (o_store_req.age_addr != o_store_req.rd_addr))
        else $error("age write collides with read");

    // Id write happens only after the scan has finished
    a_id_we_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store_req.id_we |-> (!o_store_req.rd_en && !r_pv))
        else $error("id write during scan");

    // A miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_o_found) |-> ((r_o_idx == '0) && (r_o_id == '0) && (r_o_age == '0)
                                    && !r_o_tmo))
        else $error("miss result carries nonzero fields");

    // Ages never exceed the largest limit plus one
    a_age_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store_req.age_we |-> (o_store_req.age_wdata <= {1'b1, {LIM_W{1'b0}}}))
        else $error("age written out of range");

endmodule

`default_nettype wire

>>> hdl/id_slot_table_with_timeout_core.sv
// Top level of the slot table with timeout: channels, register port, sequencer, store.
// Depends on ist_pkg, ist_in_if, ist_out_if, ist_cfg, ist_store, ist_ctrl.
//
// Usage:
//   i_req carries one request word (opcode, member_id, slot_index) with valid/ready;
//   o_rsp returns exactly one result word per request with valid/ready.
//   The APB port holds timeout_limit at byte address 0; pready is always high.
// Operation:
//   The member ids and ages live in two single-port-read memories. Join, insert
//   and tick scan every slot, one read a cycle; tick writes each age back in the
//   cycle after its read. Heard and read touch one slot.
// Sequencing:
//   join/insert/tick are paced by the one-slot-per-cycle scan of the read port.
//   The result word shows up the cycle after the sequencer finishes.
// Reset and stalls:
//   Reset clears the valid bits, so every slot reads as free with age 0, and
//   sets the limit to 5. A stalled receiver holds the result in the output
//   register; the next request is still accepted and worked on, and the
//   sequencer waits to hand over its result until the register frees up.
`default_nettype none

module id_slot_table_with_timeout_core import ist_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ist_in_if.sink                  i_req,
    ist_out_if.source               o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    logic [LIM_W-1:0] timeout_limit;
    t_store_req       store_req;
    t_store_rd        store_rd;

    // Limit register
    ist_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_timeout_limit (timeout_limit)
    );

    // Id and age memories
    ist_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rd    (store_rd)
    );

    // Scan sequencer and result register
    ist_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_limit (timeout_limit),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .o_store_req     (store_req),
        .i_store_rd      (store_rd)
    );

endmodule

`default_nettype wire

>>> verif/id_slot_table_with_timeout_core_tb.sv
// Self-checking bench for id_slot_table_with_timeout_core: directed and random requests,
// APB limit writes, stalls on both channels, and an in-order scoreboard of replies.
// Depends on ist_pkg, ist_in_if, ist_out_if and the core from the RTL.

module id_slot_table_with_timeout_core_tb import ist_pkg::*; ();

    // Opcodes the block does not decode; they must still return an empty reply.
    localparam t_opcode OP_SPARE_FIRST = 3'd5;
    localparam t_opcode OP_SPARE_LAST  = 3'd7;

    // Byte address of timeout_limit on the APB port.
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_TIMEOUT_LIMIT, 2'b00};

    localparam int RANDOM_PER_PHASE = 190;
    localparam int PHASES           = 8;

    // One reply word as it appears on o_rsp.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  index;
        logic [ID_W-1:0]   id;
        logic              timed_out;
        logic [AGE_W-1:0]  age;
    } t_reply;

    // Mirror of the slot table: ids, ages and limit, plus the replies still owed.
    class membership_tracker;
        logic [ID_W-1:0]  ids  [TABLE_SLOTS];
        logic [AGE_W-1:0] ages [TABLE_SLOTS];
        logic [LIM_W-1:0] limit;
        t_reply           pending [$];
        int               mismatches;

        function new();
            foreach (ids[i]) begin
                ids[i]  = '0;
                ages[i] = '0;
            end
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        // First slot whose id equals the key; a zero key finds the first free slot.
        function int first_holding(logic [ID_W-1:0] key);
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (ids[i] == key) return i;
            end
            return -1;
        endfunction

        // Apply one accepted request to the mirror and queue the reply it owes.
        function void note_request(t_opcode op, logic [ID_W-1:0] id, logic [IDX_W-1:0] idx);
            t_reply      rep;
            int          slot;
            int unsigned aged;
            rep  = '0;
            slot = -1;
            case (op) inside
                OP_JOIN, OP_INSERT: begin
                    if (op == OP_JOIN) slot = first_holding(id);
                    if (slot < 0) begin
                        slot = first_holding('0);
                        if (slot >= 0) ids[slot] = id;
                    end
                end
                OP_TICK: begin
                    // Age every slot, saturate at limit+1, and park free slots there.
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        aged = ages[i] + 32'd1;
                        if (ids[i] == '0 || aged > limit) aged = limit + 32'd1;
                        ages[i] = aged[AGE_W-1:0];
                    end
                end
                OP_HEARD: begin
                    if (idx < TABLE_SLOTS) begin
                        ages[idx] = '0;
                        slot      = idx;
                    end
                end
                OP_READ: begin
                    if (idx < TABLE_SLOTS) slot = idx;
                end
                default: ;
            endcase
            if (slot >= 0) begin
                rep.found     = 1'b1;
                rep.index     = IDX_W'(slot);
                rep.id        = ids[slot];
                rep.timed_out = (ages[slot] > limit);
                rep.age       = ages[slot];
            end
            pending.push_back(rep);
        endfunction

        // Compare one delivered reply against the oldest one owed.
        function void check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                $error("reply with no request outstanding: found=%0d index=%0d id=%0d",
                       got.found, got.index, got.id);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.index !== want.index) begin
                $error("result_index: expected %0d, got %0d", want.index, got.index);
                mismatches++;
            end
            if (got.id !== want.id) begin
                $error("slot_id: expected %0d, got %0d", want.id, got.id);
                mismatches++;
            end
            if (got.timed_out !== want.timed_out) begin
                $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
                mismatches++;
            end
            if (got.age !== want.age) begin
                $error("slot_age: expected %0d, got %0d", want.age, got.age);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ist_in_if  req_if ();
    ist_out_if rsp_if ();

    membership_tracker tracker;

    int   burst_left    = 0;     // words left in the current sender burst
    int   replies_taken = 0;     // replies accepted so far, drives the long hold-off
    int   rx_cycle      = 0;     // receiver pattern clock
    logic hold_off      = 1'b0;  // receiver long stall in progress

    id_slot_table_with_timeout_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Offer one request word, hold it until the block takes it, then note it
    // in the tracker. At the end of a burst, unless the drawn gap is zero, drop
    // valid and idle a while; inside a burst, leave valid high so the next word follows back to back.
    task automatic offer(input t_opcode op, input logic [ID_W-1:0] id,
                         input logic [IDX_W-1:0] idx);
        int gap;
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.member_id  <= id;
        req_if.slot_index <= idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        tracker.note_request(op, id, idx);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and hold until every owed reply has come back; always
    // advance at least one edge so the next drive lands in a later step.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (tracker.pending.size() != 0);
    endtask

    // APB write of timeout_limit: setup cycle, then access until pready.
    task automatic set_limit(input logic [LIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.limit = value;
    endtask

    // Receiver: cycle through always-ready, coin-flip, sparse and alternating
    // windows in turn; the long hold-off overrides all of them.
    always @(posedge i_clk) begin
        case ((rx_cycle / 64) % 4)
            0:       rsp_if.ready <= !hold_off;
            1:       rsp_if.ready <= !hold_off && ($urandom_range(0, 1) == 1);
            2:       rsp_if.ready <= !hold_off && ($urandom_range(0, 7) == 0);
            default: rsp_if.ready <= !hold_off && rx_cycle[0];
        endcase
        rx_cycle++;
    end

    // Reply monitor: sample at the edge that completes the handshake.
    always @(posedge i_clk) begin : collect
        t_reply got;
        if (i_rst_n === 1'b1 && rsp_if.valid && rsp_if.ready) begin
            got.found     = rsp_if.found;
            got.index     = rsp_if.result_index;
            got.id        = rsp_if.slot_id;
            got.timed_out = rsp_if.timed_out;
            got.age       = rsp_if.slot_age;
            tracker.check_reply(got);
            replies_taken++;
        end
    end

    // Long receiver hold-off mid-run: the sender keeps offering, so the
    // output register and the sequencer fill and the input must back up.
    initial begin : long_hold
        wait (replies_taken >= 150);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [LIM_W-1:0] phase_limits [PHASES];
        t_opcode          op;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        int               pick;

        tracker = new();
        phase_limits = '{16'd0, 16'd65535, 16'd40, 16'd2, 16'd1, 16'd9, 16'd65534, 16'd3};

        // Drive every input to a known value before the first edge; the
        // receiver process owns ready.
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.opcode     <= OP_JOIN;
        req_if.member_id  <= '0;
        req_if.slot_index <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= LIMIT_ADDR;
        pwdata            <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, widest limit: free slots saturate at 65536, which a
        // newly taken slot then inherits and shows as timed out.
        set_limit(16'hFFFF);
        offer(OP_TICK,   16'h0000, 4'h0);
        offer(OP_JOIN,   16'hFFFF, 4'hF);
        offer(OP_JOIN,   16'hFFFF, 4'h0);   // matches the slot just taken
        offer(OP_JOIN,   16'h0000, 4'h0);   // id zero finds a free slot, no write
        offer(OP_INSERT, 16'h0000, 4'h0);   // returned slot stays free
        offer(OP_INSERT, 16'hFFFF, 4'h0);   // duplicate id, no match check
        offer(OP_HEARD,  16'hFFFF, 4'h0);
        offer(OP_READ,   16'h0000, 4'hF);
        for (int s = OP_SPARE_FIRST; s <= OP_SPARE_LAST; s++) begin
            offer(t_opcode'(s), 16'hFFFF, 4'hF);
        end

        // Drop the limit to zero: the next tick clamps every age to 1.
        wait_drained();
        set_limit(16'h0000);
        offer(OP_TICK, 16'h0000, 4'h0);
        offer(OP_READ, 16'h0000, 4'h1);

        // Fill the remaining slots, then hit the full table three ways.
        for (int k = 0; k < TABLE_SLOTS - 2; k++) begin
            offer(OP_INSERT, ID_W'(k * 4679 + 1), IDX_W'(k));
        end
        offer(OP_JOIN,   16'h1234, 4'h0);
        offer(OP_INSERT, 16'h5678, 4'h0);
        offer(OP_JOIN,   16'h0000, 4'h0);

        // Random phases, each under its own limit; the limit only moves
        // once the block has handed back everything it owes.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_limit(phase_limits[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                // Half the ids come from the table so joins hit existing members.
                id   = ($urandom_range(0, 1) == 1) ?
                       tracker.ids[$urandom_range(0, TABLE_SLOTS - 1)] : ID_W'($urandom);
                idx  = IDX_W'($urandom);
                if (pick < 25)      op = OP_JOIN;
                else if (pick < 30) op = OP_INSERT;
                else if (pick < 55) op = OP_TICK;
                else if (pick < 75) op = OP_HEARD;
                else if (pick < 95) op = OP_READ;
                else                op = t_opcode'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                offer(op, id, idx);
                // Occasionally pause the sender until the pipe is empty.
                if ($urandom_range(0, 149) == 0) wait_drained();
            end
        end

        // Drain, then leave room for any stray extra reply to show up.
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
